// ----- src/lmtf_pkg.sv -----
// Package: shared widths, action codes and cell control type for the LRU list.
`default_nettype none
package lmtf_pkg;

    localparam int KEY_W = 32;
    localparam int CFG_W = 5;
    localparam int POS_W = 4;
    localparam int OCC_W = 5;

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_PROBE  = 1'b1;

    // Per-cell control, decoded at the top from the transaction, fill count and capacity
    typedef struct packed {
        logic update;    // access transaction in its work cycle
        logic occupied;  // position below fill count
        logic shift_ok;  // position may take its neighbor's key
        logic is_last;   // position is capacity - 1
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- src/lmtf_cell.sv -----
// One list position: holds a key, compares it, shifts in from its neighbor.
`default_nettype none
module lmtf_cell (
    input  wire logic                       i_clk,
    input  wire lmtf_pkg::t_cell_ctl        i_ctl,
    input  wire logic [lmtf_pkg::KEY_W-1:0] i_key,
    input  wire logic [lmtf_pkg::KEY_W-1:0] i_prev,
    input  wire logic                       i_seen,
    output logic                            o_seen,
    output logic                            o_match,
    output logic [lmtf_pkg::KEY_W-1:0]      o_entry,
    output logic [lmtf_pkg::KEY_W-1:0]      o_evict
);
    import lmtf_pkg::*;

    logic [KEY_W-1:0] r_entry;
    logic             w_shift;

    assign o_match = i_ctl.occupied && (r_entry == i_key);
    assign o_seen  = i_seen | o_match;
    assign o_entry = r_entry;
    assign o_evict = i_ctl.is_last ? r_entry : '0;

    // shift up to and including the matching cell; none after it
    assign w_shift = i_ctl.update && !i_seen && i_ctl.shift_ok;

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_entry <= i_prev;
        end
    end

endmodule
`default_nettype wire

// ----- src/lru_move_to_front_list.sv -----
// Top level: LRU move-to-front list built from a row of key cells.
// Result: start, once accepted, is registered as the work cycle, then as the result strobe.
// A new start is not taken while busy; busy is high for the one cycle in
//   which the cell row compares all keys and shifts in place.
// Reset (synchronous, active low): list empty, capacity = min(16, DEPTH).
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module lru_move_to_front_list #(
    parameter int DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_action,
    input  wire logic signed [lmtf_pkg::KEY_W-1:0] i_key,
    input  wire logic                              i_cfg_we,
    input  wire logic [lmtf_pkg::CFG_W-1:0]        i_cfg_wdata,
    output logic                                   o_strobe,
    output logic                                   o_hit,
    output logic [lmtf_pkg::POS_W-1:0]             o_hit_position,
    output logic                                   o_evicted_valid,
    output logic signed [lmtf_pkg::KEY_W-1:0]      o_evicted_key,
    output logic [lmtf_pkg::OCC_W-1:0]             o_occupancy
);
    import lmtf_pkg::*;

    localparam int CW      = $clog2(DEPTH + 1);   // holds 0..DEPTH
    localparam int IDX_W   = $clog2(DEPTH);       // position index
    localparam int CAP_RST = (16 < DEPTH) ? 16 : DEPTH;

    // transaction capture
    logic             r_pending;
    logic             r_action;
    logic [KEY_W-1:0] r_key;

    // list control state
    logic [CW-1:0]    r_cap;
    logic [CW-1:0]    r_fill;
    logic [CW-1:0]    n_fill;

    // result registers
    logic             r_strobe;
    logic             r_hit;
    logic [POS_W-1:0] r_pos;
    logic             r_evv;
    logic [KEY_W-1:0] r_evk;
    logic [OCC_W-1:0] r_occ;

    // cell row wiring
    t_cell_ctl        w_ctl   [DEPTH];
    logic [KEY_W-1:0] w_entry [DEPTH];
    logic [KEY_W-1:0] w_evict [DEPTH];
    logic [DEPTH:0]   w_seen;
    logic [DEPTH-1:0] w_match;

    logic             w_hit;
    logic [IDX_W-1:0] w_pos;
    logic [KEY_W-1:0] w_evk;
    logic             w_access;
    logic             w_full;
    logic             w_evv;
    logic [CW-1:0]    w_cap_new;

    assign busy     = r_pending;
    assign w_access = (r_action == ACT_ACCESS);
    assign w_full   = (r_fill >= r_cap);
    assign w_hit    = w_seen[DEPTH];
    assign w_evv    = w_access && !w_hit && w_full;
    assign w_seen[0] = 1'b0;

    // ---------------------------------------------------------------
    // Cell row: cell 0 loads the new key, cell i loads cell i-1.
    // Keys in occupied cells are unique, so at most one cell matches.
    // ---------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        always_comb begin
            w_ctl[g].update   = r_pending && w_access;
            w_ctl[g].occupied = (CW'(g) < r_fill);
            w_ctl[g].shift_ok = (CW'(g) <= r_fill) && (CW'(g) < r_cap);
            w_ctl[g].is_last  = (CW'(g + 1) == r_cap);
        end

        lmtf_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_key   (r_key),
            .i_prev  ((g == 0) ? r_key : w_entry[(g == 0) ? 0 : g - 1]),
            .i_seen  (w_seen[g]),
            .o_seen  (w_seen[g+1]),
            .o_match (w_match[g]),
            .o_entry (w_entry[g]),
            .o_evict (w_evict[g])
        );
    end

    // Position encode and evicted-key select: single hot source, OR-reduce
    always_comb begin
        w_pos = '0;
        w_evk = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_match[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
            w_evk = w_evk | w_evict[i];
        end
    end

    // Fill count after this transaction; probes leave it alone
    always_comb begin
        n_fill = r_fill;
        if (r_pending && w_access && !w_hit && !w_full) begin
            n_fill = r_fill + CW'(1);
        end
    end

    // Capacity write: 0 acts as 1, above DEPTH acts as DEPTH
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cap_new = CW'(1);
        end else if (32'(i_cfg_wdata) > 32'(DEPTH)) begin
            w_cap_new = CW'(DEPTH);
        end else begin
            w_cap_new = CW'(i_cfg_wdata);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_strobe  <= 1'b0;
            r_cap     <= CW'(CAP_RST);
            r_fill    <= '0;
        end else begin
            r_pending <= start && !r_pending;
            r_strobe  <= r_pending;
            if (i_cfg_we) begin
                r_cap <= w_cap_new;
                // lowering capacity drops tail keys silently
                if (r_fill > w_cap_new) begin
                    r_fill <= w_cap_new;
                end
            end else begin
                r_fill <= n_fill;
            end
        end
    end

    // Payload capture and result registers
    always_ff @(posedge i_clk) begin
        if (start && !r_pending) begin
            r_action <= i_action;
            r_key    <= i_key;
        end
        if (r_pending) begin
            r_hit <= w_hit;
            r_pos <= w_hit ? POS_W'(w_pos) : '0;
            r_evv <= w_evv;
            r_evk <= w_evv ? w_evk : '0;
            r_occ <= OCC_W'(n_fill);
        end
    end

    assign o_strobe        = r_strobe;
    assign o_hit           = r_hit;
    assign o_hit_position  = r_pos;
    assign o_evicted_valid = r_evv;
    assign o_evicted_key   = r_evk;
    assign o_occupancy     = r_occ;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fill_le_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_cap)
        else $error("fill count exceeds capacity");

    a_match_unique : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> $onehot0(w_match))
        else $error("more than one cell matched the key");

    a_strobe_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |=> (o_strobe && !busy))
        else $error("work cycle not followed by a result strobe");

    a_evict_is_miss : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_evicted_valid) |-> !o_hit)
        else $error("eviction reported on a hit");

endmodule
`default_nettype wire

// ----- verif/tb_lru_move_to_front_list.sv -----
// Testbench for the LRU move-to-front list: random and directed traffic, self-checking.
module tb_lru_move_to_front_list;
    import lmtf_pkg::*;

    localparam int DEPTH     = 16;
    localparam int SETTLE    = 3;        // quiet cycles before a capacity write
    localparam int MAX_PRINT = 50;       // mismatch lines printed before going silent

    // One pending stimulus entry: either a list transaction or a capacity write
    typedef struct {
        bit                        is_cfg;
        logic                      action;
        logic signed [KEY_W-1:0]   key;
        logic [CFG_W-1:0]          cap_val;
        int                        gap;    // idle cycles after this transaction is taken
    } t_list_req;

    // Expected response of one transaction
    typedef struct {
        logic                      hit;
        logic [POS_W-1:0]          hit_pos;
        logic                      ev_valid;
        logic signed [KEY_W-1:0]   ev_key;
        logic [OCC_W-1:0]          occ;
    } t_list_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          i_action = ACT_ACCESS;
    logic signed [KEY_W-1:0]       i_key = '0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_W-1:0]              i_cfg_wdata = '0;
    logic                          busy;
    logic                          o_strobe;
    logic                          o_hit;
    logic [POS_W-1:0]              o_hit_position;
    logic                          o_evicted_valid;
    logic signed [KEY_W-1:0]       o_evicted_key;
    logic [OCC_W-1:0]              o_occupancy;

    lru_move_to_front_list #(.DEPTH(DEPTH)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_key           (i_key),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_hit           (o_hit),
        .o_hit_position  (o_hit_position),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_key   (o_evicted_key),
        .o_occupancy     (o_occupancy)
    );

    always #2 i_clk = ~i_clk;

    t_list_req     pending_q[$];      // stimulus not yet presented
    t_list_result  lru_expect_q[$];   // responses owed by the block, oldest first
    int            mismatch_cnt = 0;
    int            idle_left = 0;
    int            quiet_cnt = 0;

    // Shadow copy of the list, kept in step with accepted transactions
    logic [KEY_W-1:0]  shadow_list[DEPTH];
    int                shadow_fill = 0;
    logic [CFG_W-1:0]  shadow_cap = 5'd16;

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINT)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // A written capacity of 0 behaves as 1, anything above the built depth as DEPTH
    function automatic int eff_capacity(input logic [CFG_W-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > DEPTH)
            return DEPTH;
        return int'(cap);
    endfunction

    // Shift positions 0..last-1 back by one and place the key at the front
    task automatic shadow_to_front(input int last, input logic [KEY_W-1:0] key);
        for (int i = last; i > 0; i--)
            shadow_list[i] = shadow_list[i-1];
        shadow_list[0] = key;
    endtask

    task automatic shadow_set_capacity(input logic [CFG_W-1:0] cap);
        shadow_cap = cap;
        if (shadow_fill > eff_capacity(cap))
            shadow_fill = eff_capacity(cap);
    endtask

    // Work out the response of one transaction and advance the shadow list
    task automatic lru_lookup_update(input logic act, input logic [KEY_W-1:0] key,
                                     output t_list_result r);
        int  cap;
        int  fill;
        int  pos;
        bit  found;
        cap   = eff_capacity(shadow_cap);
        fill  = (shadow_fill > cap) ? cap : shadow_fill;
        pos   = 0;
        found = 1'b0;
        r.ev_valid = 1'b0;
        r.ev_key   = '0;
        for (int i = 0; i < fill; i++) begin
            if (!found && shadow_list[i] == key) begin
                found = 1'b1;
                pos   = i;
            end
        end
        if (act == ACT_ACCESS) begin
            if (found) begin
                shadow_to_front(pos, key);
            end else if (fill >= cap) begin
                // full list: the tail key falls off and is reported
                r.ev_valid = 1'b1;
                r.ev_key   = shadow_list[cap-1];
                shadow_to_front(cap - 1, key);
            end else begin
                shadow_to_front(fill, key);
                fill++;
            end
            shadow_fill = fill;
        end
        r.hit     = found;
        r.hit_pos = found ? pos[POS_W-1:0] : '0;
        r.occ     = shadow_fill[OCC_W-1:0];
    endtask

    // Mostly back-to-back, some short pauses, a few long ones
    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_xact(input logic act, input logic [KEY_W-1:0] key, input bit no_idle);
        t_list_req t;
        t.is_cfg  = 1'b0;
        t.action  = act;
        t.key     = key;
        t.cap_val = '0;
        t.gap     = pick_gap(no_idle);
        pending_q.push_back(t);
    endtask

    task automatic queue_capacity(input logic [CFG_W-1:0] cap);
        t_list_req t;
        t.is_cfg  = 1'b1;
        t.action  = ACT_ACCESS;
        t.key     = '0;
        t.cap_val = cap;
        t.gap     = 0;
        pending_q.push_back(t);
    endtask

    // Driver: everything changes on the falling edge. A transaction stays on
    // the port until an edge with busy low takes it; busy is high in the cycle
    // right after a take, so start with busy low here means not taken yet.
    // A capacity write waits until every owed response has come back and the
    // block has gone quiet.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                i_cfg_we <= 1'b0;
            end
            quiet_cnt <= (lru_expect_q.size() == 0) ? quiet_cnt + 1 : 0;
            if (start && !busy) begin
                // still waiting for the block to take it
            end else if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                start     <= 1'b0;
            end else if (pending_q.size() == 0) begin
                start <= 1'b0;
            end else if (pending_q[0].is_cfg) begin
                start <= 1'b0;
                if (lru_expect_q.size() == 0 && quiet_cnt >= SETTLE && !i_cfg_we) begin
                    i_cfg_we    <= 1'b1;
                    i_cfg_wdata <= pending_q[0].cap_val;
                    void'(pending_q.pop_front());
                end
            end else begin
                start     <= 1'b1;
                i_action  <= pending_q[0].action;
                i_key     <= pending_q[0].key;
                idle_left <= pending_q[0].gap;
                void'(pending_q.pop_front());
            end
        end
    end

    // Monitor: samples on the rising edge, before the block's own updates land.
    // Capacity writes and accepted transactions feed the shadow list in order;
    // each strobed response is held against the oldest owed one.
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (i_rst_n) begin
            if (i_cfg_we)
                shadow_set_capacity(i_cfg_wdata);
            if (o_strobe) begin
                got.hit      = o_hit;
                got.hit_pos  = o_hit_position;
                got.ev_valid = o_evicted_valid;
                got.ev_key   = o_evicted_key;
                got.occ      = o_occupancy;
                if (lru_expect_q.size() == 0) begin
                    report_mismatch("response strobed with nothing outstanding");
                end else begin
                    want = lru_expect_q.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
                    if (got.hit_pos !== want.hit_pos)
                        report_mismatch($sformatf("hit_position %0d, want %0d",
                                                  got.hit_pos, want.hit_pos));
                    if (got.ev_valid !== want.ev_valid)
                        report_mismatch($sformatf("evicted_valid %b, want %b",
                                                  got.ev_valid, want.ev_valid));
                    if (got.ev_key !== want.ev_key)
                        report_mismatch($sformatf("evicted_key %h, want %h",
                                                  got.ev_key, want.ev_key));
                    if (got.occ !== want.occ)
                        report_mismatch($sformatf("occupancy %0d, want %0d",
                                                  got.occ, want.occ));
                end
            end
            if (start && !busy) begin
                lru_lookup_update(i_action, i_key, want);
                lru_expect_q.push_back(want);
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stim
        logic [KEY_W-1:0]  key_pool[$];
        logic [CFG_W-1:0]  phase_caps[8];
        logic [KEY_W-1:0]  k;
        logic              act;
        int                pool_n;
        bit                no_idle;
        int                wait_cnt;

        // --- directed part: reset capacity is 16 ---
        queue_xact(ACT_PROBE,  32'h8000_0000, 1'b0);   // probe of an empty list
        queue_xact(ACT_ACCESS, 32'h8000_0000, 1'b0);   // first insert
        queue_xact(ACT_ACCESS, 32'h8000_0000, 1'b0);   // hit at the front
        queue_xact(ACT_ACCESS, 32'h7FFF_FFFF, 1'b0);
        queue_xact(ACT_ACCESS, 32'h0000_0000, 1'b0);
        queue_xact(ACT_ACCESS, 32'hFFFF_FFFF, 1'b0);
        queue_xact(ACT_PROBE,  32'h8000_0000, 1'b0);   // probe hit at the tail
        queue_xact(ACT_ACCESS, 32'h8000_0000, 1'b0);   // hit at the tail moves to front
        for (int i = 1; i <= 12; i++)
            queue_xact(ACT_ACCESS, 32'h1111_1111 * i, 1'b0);   // fill to 16
        queue_xact(ACT_PROBE,  32'h7FFF_FFFF, 1'b0);   // probe at position 15
        queue_xact(ACT_ACCESS, 32'h5A5A_A5A5, 1'b0);   // miss on a full list evicts
        queue_xact(ACT_PROBE,  32'h1234_5678, 1'b0);   // probe miss, nothing changes
        // capacity cut below occupancy drops the tail silently
        queue_capacity(5'd2);
        queue_xact(ACT_ACCESS, 32'hCCCC_CCCC, 1'b0);   // hit at position 1
        queue_xact(ACT_ACCESS, 32'h0F0F_F0F0, 1'b0);   // evicts from a list of two
        // capacity 0 behaves as one entry
        queue_capacity(5'd0);
        queue_xact(ACT_ACCESS, 32'h0F0F_F0F0, 1'b0);
        queue_xact(ACT_ACCESS, 32'hF0F0_0F0F, 1'b0);

        // --- random part: phases over several capacities, keys mostly from a
        // pool a little larger than the list so hits, misses and evictions mix ---
        phase_caps = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd17, 5'd9, 5'd16};
        phase_caps[6] = CFG_W'($urandom_range(0, 31));
        foreach (phase_caps[p]) begin
            queue_capacity(phase_caps[p]);
            pool_n  = eff_capacity(phase_caps[p]) + $urandom_range(1, 6);
            no_idle = ($urandom_range(0, 2) == 0);
            key_pool.delete();
            for (int i = 0; i < pool_n; i++) begin
                case ($urandom_range(0, 7))
                    0:       key_pool.push_back(32'h8000_0000);
                    1:       key_pool.push_back(32'h7FFF_FFFF);
                    default: key_pool.push_back($urandom);
                endcase
            end
            for (int n = 0; n < 175; n++) begin
                act = ($urandom_range(0, 9) < 7) ? ACT_ACCESS : ACT_PROBE;
                if ($urandom_range(0, 9) == 0)
                    k = $urandom;
                else
                    k = key_pool[$urandom_range(0, pool_n - 1)];
                queue_xact(act, k, no_idle);
            end
        end

        // Reset held, then released on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All stimulus presented and taken
        while (pending_q.size() != 0 || start || i_cfg_we)
            @(posedge i_clk);
        // Drain: wait for every owed response to come back
        wait_cnt = 0;
        while (lru_expect_q.size() != 0 && wait_cnt < 200) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (4) @(posedge i_clk);
        if (lru_expect_q.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", lru_expect_q.size()));

        if (mismatch_cnt == 0) begin
            $display("lru_move_to_front_list regression: pass");
        end else begin
            $display("lru_move_to_front_list regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("lru_move_to_front_list regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
src/lmtf_pkg.sv
src/lmtf_cell.sv
src/lru_move_to_front_list.sv
verif/tb_lru_move_to_front_list.sv
